// ===== rtl/core/sab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_pkg - shared types and constants of the buffer slot allocator
// pool size, stream count, id width, request and response layouts, codes
// ----------------------------------------------------------------------------
package sab_pkg;

  // pool geometry
  localparam int NUM_SLOTS   = 16;
  localparam int NUM_STREAMS = 8;
  localparam int ID_WIDTH    = 48;

  // field widths
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int STREAM_W = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 32;
  localparam int MASK_W   = NUM_STREAMS;
  localparam int SBIT_W   = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_USE      = 3'd1;
  localparam logic [OP_W-1:0] OP_RECORD   = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd3;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd4;

  // response status codes
  localparam logic [STATUS_W-1:0] RC_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] RC_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] RC_STATE   = 3'd2;
  localparam logic [STATUS_W-1:0] RC_STREAM  = 3'd3;
  localparam logic [STATUS_W-1:0] RC_NOTPEND = 3'd4;
  localparam logic [STATUS_W-1:0] RC_IDFULL  = 3'd5;

  // per-slot life cycle
  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_ALLOC = 2'd1,
    SLOT_INUSE = 2'd2,
    SLOT_PEND  = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SLOT_W-1:0]   buffer_index;
    logic [STREAM_W-1:0] stream;
  } sab_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_index;
    logic [ID_WIDTH-1:0] granted_id;
    logic                deferred;
    logic [COUNT_W-1:0]  free_slots;
    logic [COUNT_W-1:0]  pending_slots;
    logic [TOTAL_W-1:0]  alloc_total;
    logic [TOTAL_W-1:0]  free_total;
  } sab_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted request
    logic commit;  // execute it and load the response register
  } sab_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sab_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_stream_if - valid/ready channel
// carries one payload item per handshake
// ----------------------------------------------------------------------------
interface sab_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sab_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_ctrl - request sequencer of the buffer slot allocator
// takes a request, runs it once the response register is free
// ----------------------------------------------------------------------------
module sab_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sab_pkg::sab_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        rsp_free;

  assign rsp_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (rsp_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/sab_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_datapath - slot table, free stack and counters
// executes one captured request per commit and registers the response
// ----------------------------------------------------------------------------
module sab_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sab_pkg::sab_cmd_t cmd,
  input  wire sab_pkg::sab_req_t req,
  output sab_pkg::sab_rsp_t      rsp
);

  localparam int SLOT_W  = sab_pkg::SLOT_W;
  localparam int COUNT_W = sab_pkg::COUNT_W;
  localparam int MASK_W  = sab_pkg::MASK_W;
  localparam int ID_W    = sab_pkg::ID_WIDTH;
  localparam int TOT_W   = sab_pkg::TOTAL_W;
  localparam int NSLOT   = sab_pkg::NUM_SLOTS;

  sab_pkg::sab_req_t    req_r;
  sab_pkg::slot_state_t slot_state_r [NSLOT];
  logic [MASK_W-1:0]    slot_mask_r  [NSLOT];
  logic [SLOT_W-1:0]    free_stack_r [NSLOT];
  logic [COUNT_W-1:0]   free_depth_r, free_depth_nxt;
  logic [COUNT_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [ID_W-1:0]      id_cnt_r, id_cnt_nxt;
  logic [TOT_W-1:0]     alloc_cnt_r, alloc_cnt_nxt;
  logic [TOT_W-1:0]     free_cnt_r, free_cnt_nxt;
  sab_pkg::sab_rsp_t    rsp_r, rsp_nxt;

  logic [SLOT_W-1:0]                 idx;
  logic                              idx_ok;
  logic                              stream_ok;
  logic [sab_pkg::STREAM_W-1:0]      stream_m1;
  logic [MASK_W-1:0]                 stream_bit;
  sab_pkg::slot_state_t              cur_state;
  logic [MASK_W-1:0]                 cur_mask;
  logic                              multi_stream;
  logic                              busy_slot;
  logic [COUNT_W-1:0]                top_ptr;
  logic [SLOT_W-1:0]                 top_slot;
  logic                              do_alloc, do_use, do_record, do_defer, do_release;

  // operand decode
  assign idx        = req_r.buffer_index;
  assign idx_ok     = {1'b0, idx} < COUNT_W'(NSLOT);
  assign stream_ok  = (req_r.stream != '0) &&
                      (req_r.stream <= sab_pkg::STREAM_W'(sab_pkg::NUM_STREAMS));
  assign stream_m1  = req_r.stream - sab_pkg::STREAM_W'(1);
  assign stream_bit = MASK_W'(1) << stream_m1[sab_pkg::SBIT_W-1:0];
  assign cur_state  = slot_state_r[idx];
  assign cur_mask   = slot_mask_r[idx];
  // more than one bit set
  assign multi_stream = (cur_mask & (cur_mask - MASK_W'(1))) != '0;
  assign busy_slot    = (cur_state == sab_pkg::SLOT_ALLOC) ||
                        (cur_state == sab_pkg::SLOT_INUSE);
  assign top_ptr      = free_depth_r - COUNT_W'(1);
  assign top_slot     = free_stack_r[top_ptr[SLOT_W-1:0]];

  always_comb begin
    do_alloc   = 1'b0;
    do_use     = 1'b0;
    do_record  = 1'b0;
    do_defer   = 1'b0;
    do_release = 1'b0;
    rsp_nxt    = '0;
    rsp_nxt.status = sab_pkg::RC_OK;
    case (req_r.operation)
      sab_pkg::OP_ALLOC: begin
        if (!stream_ok) begin
          rsp_nxt.status = sab_pkg::RC_STREAM;
        end else if (free_depth_r == '0) begin
          rsp_nxt.status = sab_pkg::RC_EMPTY;
        end else if (id_cnt_r == '1) begin
          rsp_nxt.status = sab_pkg::RC_IDFULL;
        end else begin
          do_alloc = 1'b1;
        end
      end
      sab_pkg::OP_USE: begin
        if (!idx_ok || cur_state != sab_pkg::SLOT_ALLOC) begin
          rsp_nxt.status = sab_pkg::RC_STATE;
        end else begin
          do_use = 1'b1;
        end
      end
      sab_pkg::OP_RECORD: begin
        if (!stream_ok) begin
          rsp_nxt.status = sab_pkg::RC_STREAM;
        end else if (!idx_ok || !busy_slot) begin
          rsp_nxt.status = sab_pkg::RC_STATE;
        end else begin
          do_record = 1'b1;
        end
      end
      sab_pkg::OP_FREE: begin
        if (!idx_ok || !busy_slot) begin
          rsp_nxt.status = sab_pkg::RC_STATE;
        end else if (multi_stream) begin
          do_defer = 1'b1;
        end else begin
          do_release = 1'b1;
        end
      end
      sab_pkg::OP_COMPLETE: begin
        if (!idx_ok) begin
          rsp_nxt.status = sab_pkg::RC_STATE;
        end else if (cur_state != sab_pkg::SLOT_PEND) begin
          rsp_nxt.status = sab_pkg::RC_NOTPEND;
        end else begin
          do_release = 1'b1;
        end
      end
      default: ;
    endcase

    // counters after the request
    free_depth_nxt = free_depth_r;
    pend_cnt_nxt   = pend_cnt_r;
    id_cnt_nxt     = id_cnt_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    free_cnt_nxt   = free_cnt_r;
    if (do_alloc) begin
      free_depth_nxt = top_ptr;
      id_cnt_nxt     = id_cnt_r + ID_W'(1);
      alloc_cnt_nxt  = alloc_cnt_r + TOT_W'(1);
    end
    if (do_release && free_depth_r < COUNT_W'(NSLOT)) begin
      free_depth_nxt = free_depth_r + COUNT_W'(1);
    end
    if (do_defer) begin
      pend_cnt_nxt = pend_cnt_r + COUNT_W'(1);
    end
    if (req_r.operation == sab_pkg::OP_COMPLETE && do_release && pend_cnt_r != '0) begin
      pend_cnt_nxt = pend_cnt_r - COUNT_W'(1);
    end
    if (req_r.operation == sab_pkg::OP_FREE && (do_defer || do_release)) begin
      free_cnt_nxt = free_cnt_r + TOT_W'(1);
    end

    if (do_alloc) begin
      rsp_nxt.granted_index = top_slot;
      rsp_nxt.granted_id    = id_cnt_nxt;
    end
    rsp_nxt.deferred      = do_defer;
    rsp_nxt.free_slots    = free_depth_nxt;
    rsp_nxt.pending_slots = pend_cnt_nxt;
    rsp_nxt.alloc_total   = alloc_cnt_nxt;
    rsp_nxt.free_total    = free_cnt_nxt;
  end

  // request and response registers, slot masks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
      if (do_alloc) begin
        slot_mask_r[top_slot] <= stream_bit;
      end
      if (do_record) begin
        slot_mask_r[idx] <= cur_mask | stream_bit;
      end
      if (do_release) begin
        slot_mask_r[idx] <= '0;
      end
    end
  end

  // slot states, free stack and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_state_r[i] <= sab_pkg::SLOT_FREE;
        free_stack_r[i] <= SLOT_W'(i);
      end
      free_depth_r <= COUNT_W'(NSLOT);
      pend_cnt_r   <= '0;
      id_cnt_r     <= '0;
      alloc_cnt_r  <= '0;
      free_cnt_r   <= '0;
    end else if (cmd.commit) begin
      if (do_alloc) begin
        slot_state_r[top_slot] <= sab_pkg::SLOT_ALLOC;
      end
      if (do_use) begin
        slot_state_r[idx] <= sab_pkg::SLOT_INUSE;
      end
      if (do_defer) begin
        slot_state_r[idx] <= sab_pkg::SLOT_PEND;
      end
      if (do_release) begin
        slot_state_r[idx] <= sab_pkg::SLOT_FREE;
        if (free_depth_r < COUNT_W'(NSLOT)) begin
          free_stack_r[free_depth_r[SLOT_W-1:0]] <= idx;
        end
      end
      free_depth_r <= free_depth_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      id_cnt_r     <= id_cnt_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      free_cnt_r   <= free_cnt_nxt;
    end
  end

  assign rsp = rsp_r;

endmodule
`default_nettype wire

// ===== rtl/core/stream_aware_buffer_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stream_aware_buffer_allocator - buffer slot pool with deferred release
// lifo free stack of 16 slots, per-slot state and stream mask, id stamping
// ----------------------------------------------------------------------------
// usage
//   in_req  : request channel (operation, buffer_index, stream), valid/ready
//   out_rsp : one response per request (status, grant, counters), valid/ready
//   every request, good or bad, yields exactly one response, in order
// sequencing
//   a request taken is held in the request register and executes once the
//   response register is free; a new request is taken only after the last
//   one has executed: the request register feeds a single execute step
//   that reads and updates one slot entry and the stack top, then loads
//   the response register
// reset
//   synchronous, active low; all slots free, stack entry i holds slot i,
//   counters and ids zero; usable in the cycle after reset, no sweep
// back-pressure
//   while a response waits, one more request is still taken and held; it
//   executes as soon as the response register is drained
// ----------------------------------------------------------------------------
module stream_aware_buffer_allocator (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sab_stream_if.sink    in_req,
  sab_stream_if.source  out_rsp
);

  sab_pkg::sab_cmd_t cmd;
  sab_pkg::sab_req_t req;
  sab_pkg::sab_rsp_t rsp;

  // request payload into the datapath
  assign req = in_req.payload;

  // sequencer: accepts, then commits when the response register is free
  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // slot table, free stack, counters and response register
  sab_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_rsp.payload = rsp;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for stream_aware_buffer_allocator
// drives requests over the valid/ready request channel, keeps a shadow of
// the slot pool, stack and counters, and checks every response field in order
// ----------------------------------------------------------------------------
module testbench;

  // operation codes the block treats as no-ops
  localparam logic [sab_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [sab_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [sab_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

  // stream numbers outside 1..NUM_STREAMS
  localparam logic [sab_pkg::STREAM_W-1:0] STREAM_NONE = 4'd0;
  localparam logic [sab_pkg::STREAM_W-1:0] STREAM_OVER = 4'd9;
  localparam logic [sab_pkg::STREAM_W-1:0] STREAM_TOP  = 4'd15;

  localparam int MAX_PRINTED = 50;

  // how a well-formed request picks its slot
  typedef enum int {PICK_LIVE, PICK_FRESH, PICK_PARKED} slot_pick_t;

  bit clk = 1'b0;
  logic rst_n;

  sab_stream_if #(.payload_t(sab_pkg::sab_req_t)) req_if ();
  sab_stream_if #(.payload_t(sab_pkg::sab_rsp_t)) rsp_if ();

  stream_aware_buffer_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow of the slot pool
  // --------------------------------------------------------------------------
  sab_pkg::slot_state_t         pool_state  [sab_pkg::NUM_SLOTS];
  logic [sab_pkg::ID_WIDTH-1:0] pool_id     [sab_pkg::NUM_SLOTS];
  logic [sab_pkg::STREAM_W-1:0] pool_owner  [sab_pkg::NUM_SLOTS];
  logic [sab_pkg::MASK_W-1:0]   pool_users  [sab_pkg::NUM_SLOTS];
  logic                         pool_parked [sab_pkg::NUM_SLOTS];
  logic [sab_pkg::SLOT_W-1:0]   stack_slot  [sab_pkg::NUM_SLOTS];
  logic [sab_pkg::COUNT_W-1:0]  stack_depth;
  logic [sab_pkg::COUNT_W-1:0]  parked_count;
  logic [sab_pkg::ID_WIDTH-1:0] id_seq;
  logic [sab_pkg::TOTAL_W-1:0]  alloc_count;
  logic [sab_pkg::TOTAL_W-1:0]  release_count;
  logic [sab_pkg::SLOT_W-1:0]   last_grant;   // slot of the latest successful alloc

  sab_pkg::sab_rsp_t awaited_rsp[$];  // responses owed by the block, oldest first
  int       taken_count = 0; // requests accepted so far
  int       error_count = 0;
  bit       tx_gaps;         // sender idles between requests
  bit       rx_stalls;       // receiver drops ready at random
  int       stall_left = 0;

  initial begin
    for (int i = 0; i < sab_pkg::NUM_SLOTS; i++) begin
      pool_state[i]  = sab_pkg::SLOT_FREE;
      pool_id[i]     = '0;
      pool_owner[i]  = '0;
      pool_users[i]  = '0;
      pool_parked[i] = 1'b0;
      stack_slot[i]  = sab_pkg::SLOT_W'(i);
    end
    stack_depth   = sab_pkg::COUNT_W'(sab_pkg::NUM_SLOTS);
    parked_count  = '0;
    id_seq        = '0;
    alloc_count   = '0;
    release_count = '0;
    last_grant    = '0;
  end

  function automatic bit stream_in_range(logic [sab_pkg::STREAM_W-1:0] s);
    return s >= 1 && s <= sab_pkg::NUM_STREAMS;
  endfunction

  // slot goes back on top of the stack; its id is kept
  function automatic void return_to_stack(logic [sab_pkg::SLOT_W-1:0] s);
    pool_state[s] = sab_pkg::SLOT_FREE;
    pool_owner[s] = '0;
    pool_users[s] = '0;
    if (stack_depth < sab_pkg::NUM_SLOTS) begin
      stack_slot[stack_depth] = s;
      stack_depth = stack_depth + 1'b1;
    end
  endfunction

  // applies one request to the shadow pool and returns the response it owes
  function automatic sab_pkg::sab_rsp_t pool_step(sab_pkg::sab_req_t r);
    sab_pkg::sab_rsp_t          rsp;
    logic [sab_pkg::SLOT_W-1:0] s;
    s   = r.buffer_index;
    rsp = '0;
    rsp.status = sab_pkg::RC_OK;
    case (r.operation)
      sab_pkg::OP_ALLOC: begin
        if (!stream_in_range(r.stream)) begin
          rsp.status = sab_pkg::RC_STREAM;
        end else if (stack_depth == 0) begin
          rsp.status = sab_pkg::RC_EMPTY;
        end else if (id_seq == '1) begin
          rsp.status = sab_pkg::RC_IDFULL;
        end else begin
          stack_depth = stack_depth - 1'b1;
          s = stack_slot[stack_depth];
          id_seq = id_seq + 1'b1;
          pool_state[s] = sab_pkg::SLOT_ALLOC;
          pool_id[s]    = id_seq;
          pool_owner[s] = r.stream;
          pool_users[s] = sab_pkg::MASK_W'(1) << (r.stream - 1);
          alloc_count   = alloc_count + 1'b1;
          rsp.granted_index = s;
          rsp.granted_id    = id_seq;
          last_grant        = s;
        end
      end
      sab_pkg::OP_USE: begin
        if (pool_state[s] != sab_pkg::SLOT_ALLOC) rsp.status = sab_pkg::RC_STATE;
        else pool_state[s] = sab_pkg::SLOT_INUSE;
      end
      sab_pkg::OP_RECORD: begin
        if (!stream_in_range(r.stream)) begin
          rsp.status = sab_pkg::RC_STREAM;
        end else if (pool_state[s] != sab_pkg::SLOT_ALLOC &&
                     pool_state[s] != sab_pkg::SLOT_INUSE) begin
          rsp.status = sab_pkg::RC_STATE;
        end else begin
          pool_users[s] = pool_users[s] | (sab_pkg::MASK_W'(1) << (r.stream - 1));
        end
      end
      sab_pkg::OP_FREE: begin
        if (pool_state[s] != sab_pkg::SLOT_ALLOC &&
            pool_state[s] != sab_pkg::SLOT_INUSE) begin
          rsp.status = sab_pkg::RC_STATE;
        end else begin
          // shared by several streams: park it until completion
          if ($countones(pool_users[s]) > 1) begin
            pool_state[s]  = sab_pkg::SLOT_PEND;
            pool_parked[s] = 1'b1;
            parked_count   = parked_count + 1'b1;
            rsp.deferred   = 1'b1;
          end else begin
            return_to_stack(s);
          end
          release_count = release_count + 1'b1;
        end
      end
      sab_pkg::OP_COMPLETE: begin
        if (!pool_parked[s]) begin
          rsp.status = sab_pkg::RC_NOTPEND;
        end else begin
          pool_parked[s] = 1'b0;
          if (parked_count > 0) parked_count = parked_count - 1'b1;
          return_to_stack(s);
        end
      end
      default: ;  // spare codes change nothing
    endcase
    rsp.free_slots    = stack_depth;
    rsp.pending_slots = parked_count;
    rsp.alloc_total   = alloc_count;
    rsp.free_total    = release_count;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (error_count < MAX_PRINTED)
      $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // request capture and response check, both at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    sab_pkg::sab_rsp_t want;
    sab_pkg::sab_rsp_t got;
    if (rst_n) begin
      // shadow update happens in request order, before any response check
      if (req_if.valid && req_if.ready) begin
        awaited_rsp.push_back(pool_step(req_if.payload));
        taken_count++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (awaited_rsp.size() == 0) begin
          flag_mismatch("response with none awaited", 64'd0, 64'(got));
        end else begin
          want = awaited_rsp.pop_front();
          if (got.status != want.status)
            flag_mismatch("status", 64'(want.status), 64'(got.status));
          if (got.granted_index != want.granted_index)
            flag_mismatch("granted_index", 64'(want.granted_index), 64'(got.granted_index));
          if (got.granted_id != want.granted_id)
            flag_mismatch("granted_id", 64'(want.granted_id), 64'(got.granted_id));
          if (got.deferred != want.deferred)
            flag_mismatch("deferred", 64'(want.deferred), 64'(got.deferred));
          if (got.free_slots != want.free_slots)
            flag_mismatch("free_slots", 64'(want.free_slots), 64'(got.free_slots));
          if (got.pending_slots != want.pending_slots)
            flag_mismatch("pending_slots", 64'(want.pending_slots), 64'(got.pending_slots));
          if (got.alloc_total != want.alloc_total)
            flag_mismatch("alloc_total", 64'(want.alloc_total), 64'(got.alloc_total));
          if (got.free_total != want.free_total)
            flag_mismatch("free_total", 64'(want.free_total), 64'(got.free_total));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // idling on both sides
  // --------------------------------------------------------------------------

  // mostly zero, often short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // response ready: held high, with random stalls while rx_stalls is set
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      if (rx_stalls) stall_left <= idle_length();
    end
  end

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  function automatic sab_pkg::sab_req_t make_req(logic [sab_pkg::OP_W-1:0] op,
                                                 logic [sab_pkg::SLOT_W-1:0] idx,
                                                 logic [sab_pkg::STREAM_W-1:0] s);
    sab_pkg::sab_req_t r;
    r.operation    = op;
    r.buffer_index = idx;
    r.stream       = s;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input sab_pkg::sab_req_t r);
    int gap;
    int target;
    gap = tx_gaps ? idle_length() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    target = taken_count + 1;
    while (taken_count < target) @(negedge clk);
  endtask

  // random slot in the wanted life-cycle phase, any slot if none is
  function automatic logic [sab_pkg::SLOT_W-1:0] pick_slot(slot_pick_t kind);
    logic [sab_pkg::SLOT_W-1:0] hits[$];
    bit                         ok;
    for (int i = 0; i < sab_pkg::NUM_SLOTS; i++) begin
      case (kind)
        PICK_LIVE:  ok = pool_state[i] == sab_pkg::SLOT_ALLOC ||
                         pool_state[i] == sab_pkg::SLOT_INUSE;
        PICK_FRESH: ok = pool_state[i] == sab_pkg::SLOT_ALLOC;
        default:    ok = pool_parked[i];
      endcase
      if (ok) hits.push_back(sab_pkg::SLOT_W'(i));
    end
    if (hits.size() == 0)
      return sab_pkg::SLOT_W'($urandom_range(0, sab_pkg::NUM_SLOTS - 1));
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  // mostly well-formed requests aimed at live slots, the rest raw noise
  task automatic churn_pool(input int count, input int w_alloc, input int w_use,
                            input int w_record, input int w_free, input int w_done);
    int                           r;
    logic [sab_pkg::STREAM_W-1:0] s;
    for (int n = 0; n < count; n++) begin
      s = sab_pkg::STREAM_W'($urandom_range(1, sab_pkg::NUM_STREAMS));
      if ($urandom_range(0, 99) < 10) begin
        send_request(make_req(sab_pkg::OP_W'($urandom_range(0, 7)),
                              sab_pkg::SLOT_W'($urandom_range(0, 15)),
                              sab_pkg::STREAM_W'($urandom_range(0, 15))));
      end else begin
        r = $urandom_range(0, w_alloc + w_use + w_record + w_free + w_done - 1);
        if (r < w_alloc)
          send_request(make_req(sab_pkg::OP_ALLOC,
                                sab_pkg::SLOT_W'($urandom_range(0, 15)), s));
        else if (r < w_alloc + w_use)
          send_request(make_req(sab_pkg::OP_USE, pick_slot(PICK_FRESH), s));
        else if (r < w_alloc + w_use + w_record)
          send_request(make_req(sab_pkg::OP_RECORD, pick_slot(PICK_LIVE), s));
        else if (r < w_alloc + w_use + w_record + w_free)
          send_request(make_req(sab_pkg::OP_FREE, pick_slot(PICK_LIVE), s));
        else
          send_request(make_req(sab_pkg::OP_COMPLETE, pick_slot(PICK_PARKED), s));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // misuse of a fresh pool and the spare codes: no state change, all but the spare codes are errors
  task automatic test_idle_pool_errors();
    send_request(make_req(sab_pkg::OP_USE, 4'd0, 4'd1));
    send_request(make_req(sab_pkg::OP_RECORD, 4'd3, 4'd2));
    send_request(make_req(sab_pkg::OP_FREE, 4'd15, 4'd1));
    send_request(make_req(sab_pkg::OP_COMPLETE, 4'd0, 4'd1));
    send_request(make_req(OP_SPARE_A, 4'd15, STREAM_TOP));
    send_request(make_req(OP_SPARE_B, 4'd7, 4'd8));
    send_request(make_req(OP_SPARE_C, 4'd0, STREAM_NONE));
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd0, STREAM_NONE));
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd0, STREAM_OVER));
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd15, STREAM_TOP));
    // stream check wins over the slot state check
    send_request(make_req(sab_pkg::OP_RECORD, 4'd5, STREAM_NONE));
  endtask

  // one slot through alloc, use, shared record, deferred free and completion
  task automatic test_slot_lifecycle();
    logic [sab_pkg::SLOT_W-1:0] shared;
    logic [sab_pkg::SLOT_W-1:0] solo;
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd0, 4'd1));
    shared = last_grant;
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd0,
                          sab_pkg::STREAM_W'(sab_pkg::NUM_STREAMS)));
    solo = last_grant;
    send_request(make_req(sab_pkg::OP_USE, shared, 4'd1));
    send_request(make_req(sab_pkg::OP_USE, shared, 4'd1));      // already in use
    send_request(make_req(sab_pkg::OP_RECORD, shared,
                          sab_pkg::STREAM_W'(sab_pkg::NUM_STREAMS)));
    send_request(make_req(sab_pkg::OP_RECORD, shared, STREAM_TOP));
    send_request(make_req(sab_pkg::OP_FREE, shared, 4'd1));     // two users, parked
    send_request(make_req(sab_pkg::OP_FREE, shared, 4'd1));     // parked slot
    send_request(make_req(sab_pkg::OP_USE, shared, 4'd1));
    send_request(make_req(sab_pkg::OP_COMPLETE, shared, 4'd1));
    send_request(make_req(sab_pkg::OP_COMPLETE, shared, 4'd1)); // no longer parked
    send_request(make_req(sab_pkg::OP_FREE, solo, 4'd3));       // single user, immediate
    // lifo: the slot just freed comes back first, with a fresh id
    send_request(make_req(sab_pkg::OP_ALLOC, 4'd0, 4'd4));
  endtask

  // balanced traffic with idling on both sides
  task automatic test_random_mixed();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    churn_pool(160, 30, 15, 20, 25, 10);
  endtask

  // alloc-heavy back to back, runs the stack dry
  task automatic test_random_fill();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    churn_pool(120, 60, 10, 15, 10, 5);
  endtask

  // release-heavy, drains parked slots, idling again
  task automatic test_random_drain();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    churn_pool(120, 15, 10, 15, 35, 25);
  endtask

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    tx_gaps        = 1'b1;
    rx_stalls      = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_idle_pool_errors();
    test_slot_lifecycle();
    test_random_mixed();
    test_random_fill();
    test_random_drain();

    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    // keep watching so a stray response would still be caught
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("** stream_aware_buffer_allocator: PASSED **");
    end else begin
      $display("** stream_aware_buffer_allocator: FAILED **");
    end
    $finish;
  end

  // generous bound: every request waiting out the longest gap and stall
  initial begin
    #5_000_000;
    $display("** stream_aware_buffer_allocator: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sab_pkg.sv
rtl/core/sab_stream_if.sv
rtl/core/sab_ctrl.sv
rtl/core/sab_datapath.sv
rtl/core/stream_aware_buffer_allocator.sv
tb/testbench.sv
